/* rtl/assert_macros.svh */
// Assertion helpers; empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK_RST(label, clk, rst, prop, msg)
`define ASSERT_CLK(label, clk, prop, msg)
`endif
`endif

/* rtl/rcsc_pkg.sv */
package rcsc_pkg;

  localparam int unsigned TDATA_W = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [1:0] phase_t;
  typedef logic [3:0] op_t;
  typedef logic [3:0] ev_t;

  localparam phase_t PH_IDLE = 2'd0;
  localparam phase_t PH_DETECT = 2'd1;
  localparam phase_t PH_CALL = 2'd2;
  localparam phase_t PH_SMS = 2'd3;

  localparam op_t OP_TICK = 4'd0;
  localparam op_t OP_PROCESS = 4'd1;
  localparam op_t OP_RING_PIN = 4'd2;
  localparam op_t OP_RING = 4'd3;
  localparam op_t OP_CLIP = 4'd4;
  localparam op_t OP_CMTI = 4'd5;
  localparam op_t OP_DISABLE = 4'd6;
  localparam op_t OP_ENABLE = 4'd7;
  localparam op_t OP_RESET = 4'd8;
  localparam op_t OP_POLL_RESTART = 4'd9;

  localparam ev_t EV_PIN = 4'b0001;
  localparam ev_t EV_RING = 4'b0010;
  localparam ev_t EV_CLIP = 4'b0100;
  localparam ev_t EV_CMTI = 4'b1000;

  localparam logic [CFG_IDX_W-1:0] REG_LONG_POLL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_POLL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POLL_RETRIES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RING_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DISABLE_PAUSE = 3'd4;

  localparam logic [15:0] RST_LONG_POLL = 16'd1800;
  localparam logic [15:0] RST_SHORT_POLL = 16'd60;
  localparam logic [3:0] RST_POLL_RETRIES = 4'd10;
  localparam logic [7:0] RST_RING_TIMEOUT = 8'd6;
  localparam logic [7:0] RST_DISABLE_PAUSE = 8'd15;

endpackage

/* rtl/ring_call_sms_classifier.sv */
// Ring/call/SMS classifier. Each request on the slave stream is one modem event
// (tick, process step, ring-pin edge, RING, CLIP, CMTI, disable, enable, reset,
// poll restart); each gives exactly one result on the master stream with the
// phase after the event, SMS-due and missed-call pulses and the ring-enable
// state. Each event lands in an input register; the state update then writes
// the result register from it once that register can advance, so throughput
// is one event per clock while the master side keeps up. Write configuration
// through cfg_we/cfg_index/cfg_data only while no events are in flight.
`include "assert_macros.svh"

module ring_call_sms_classifier (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [rcsc_pkg::TDATA_W-1:0]        s_tdata,   // op[3:0], no_signal[4], zero pad
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [rcsc_pkg::TDATA_W-1:0]        m_tdata,   // phase[1:0], sms_due[2],
                                                         // missed_call[3], ring_enabled[4]
  input  logic                                cfg_we,
  input  logic [rcsc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rcsc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rcsc_pkg::*;

  // configuration
  logic [15:0] long_poll_interval;
  logic [15:0] short_poll_interval;
  logic [3:0]  poll_retries;
  logic [7:0]  ring_timeout;
  logic [7:0]  disable_pause;

  // input register
  logic        in_valid;
  op_t         in_op;
  logic        in_no_signal;

  // classifier state
  phase_t      ring_phase, ring_phase_next;
  ev_t         event_flags, event_flags_next;
  logic [7:0]  pin_ring_count, pin_ring_count_next;
  logic [7:0]  ring_timer, ring_timer_next;
  logic [7:0]  pause_timer, pause_timer_next;
  logic [15:0] poll_timer, poll_timer_next;
  logic [3:0]  retries_left, retries_left_next;
  logic        sms_next, miss_next;

  // result register
  logic        out_valid;
  phase_t      out_phase;
  logic        out_sms_due;
  logic        out_missed_call;
  logic        out_ring_enabled;

  logic        advance;
  logic        step;
  logic [15:0] interval;
  logic [15:0] poll_inc;

  assign advance  = !out_valid || m_tready;
  assign step     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_poll_interval  <= RST_LONG_POLL;
      short_poll_interval <= RST_SHORT_POLL;
      poll_retries        <= RST_POLL_RETRIES;
      ring_timeout        <= RST_RING_TIMEOUT;
      disable_pause       <= RST_DISABLE_PAUSE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_POLL:     long_poll_interval  <= cfg_data;
        REG_SHORT_POLL:    short_poll_interval <= cfg_data;
        REG_POLL_RETRIES:  poll_retries        <= cfg_data[3:0];
        REG_RING_TIMEOUT:  ring_timeout        <= cfg_data[7:0];
        REG_DISABLE_PAUSE: disable_pause       <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_op        <= s_tdata[3:0];
      in_no_signal <= s_tdata[4];
    end
  end

  assign interval = (retries_left != 4'd0 || in_no_signal) ? short_poll_interval
                                                           : long_poll_interval;
  assign poll_inc = (poll_timer != 16'hFFFF) ? poll_timer + 16'd1 : poll_timer;

  always_comb begin
    ring_phase_next     = ring_phase;
    event_flags_next    = event_flags;
    pin_ring_count_next = pin_ring_count;
    ring_timer_next     = ring_timer;
    pause_timer_next    = pause_timer;
    poll_timer_next     = poll_timer;
    retries_left_next   = retries_left;
    sms_next            = 1'b0;
    miss_next           = 1'b0;
    case (in_op)
      OP_TICK: begin
        poll_timer_next = poll_inc;
        if (poll_inc >= interval) begin
          if (retries_left != 4'd0) retries_left_next = retries_left - 4'd1;
          poll_timer_next = 16'd0;
          sms_next        = 1'b1;
        end
        if (ring_timer != 8'hFF) ring_timer_next = ring_timer + 8'd1;
        if (pause_timer != 8'd0) pause_timer_next = pause_timer - 8'd1;
      end
      OP_PROCESS: begin
        case (ring_phase)
          PH_IDLE: begin
            if ((event_flags & (EV_PIN | EV_RING | EV_CLIP)) != 4'd0) begin
              event_flags_next    = 4'd0;
              pin_ring_count_next = 8'd0;
              ring_timer_next     = 8'd0;
              ring_phase_next     = PH_DETECT;
            end
          end
          PH_DETECT: begin
            if ((event_flags & (EV_RING | EV_CLIP)) != 4'd0 || pin_ring_count != 8'd0) begin
              event_flags_next = 4'd0;
              ring_phase_next  = PH_CALL;
            end else if ((event_flags & EV_CMTI) != 4'd0) begin
              retries_left_next = poll_retries;
              event_flags_next  = 4'd0;
              ring_phase_next   = PH_SMS;
            end else if (ring_timer >= ring_timeout) begin
              ring_phase_next = PH_SMS;
            end
          end
          PH_SMS: begin
            retries_left_next = poll_retries;
            sms_next          = 1'b1;
            event_flags_next  = 4'd0;
            ring_timer_next   = 8'd0;
            ring_phase_next   = PH_IDLE;
          end
          default: begin
            // call in progress: end it once ringing has stopped long enough
            if (ring_timer >= ring_timeout) begin
              miss_next        = 1'b1;
              event_flags_next = 4'd0;
              ring_phase_next  = PH_IDLE;
            end
          end
        endcase
      end
      OP_RING_PIN: begin
        event_flags_next = event_flags | EV_PIN;
        if (pin_ring_count != 8'hFF) pin_ring_count_next = pin_ring_count + 8'd1;
        ring_timer_next = 8'd0;
      end
      OP_RING: begin
        event_flags_next = event_flags | EV_RING;
        ring_timer_next  = 8'd0;
      end
      OP_CLIP: begin
        event_flags_next = event_flags | EV_CLIP;
        ring_timer_next  = 8'd0;
      end
      OP_CMTI: begin
        sms_next          = 1'b1;
        event_flags_next  = event_flags | EV_CMTI;
        retries_left_next = poll_retries;
      end
      OP_DISABLE: begin
        pause_timer_next = disable_pause;
        event_flags_next = 4'd0;
        ring_phase_next  = PH_IDLE;
      end
      OP_ENABLE: begin
        pause_timer_next = 8'd0;
      end
      OP_RESET: begin
        event_flags_next = 4'd0;
        ring_phase_next  = PH_IDLE;
        pause_timer_next = 8'd1;
      end
      OP_POLL_RESTART: begin
        poll_timer_next = 16'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_phase     <= PH_IDLE;
      event_flags    <= 4'd0;
      pin_ring_count <= 8'd0;
      ring_timer     <= 8'd0;
      pause_timer    <= 8'd0;
      poll_timer     <= 16'd0;
      retries_left   <= RST_POLL_RETRIES;
    end else if (step) begin
      ring_phase     <= ring_phase_next;
      event_flags    <= event_flags_next;
      pin_ring_count <= pin_ring_count_next;
      ring_timer     <= ring_timer_next;
      pause_timer    <= pause_timer_next;
      poll_timer     <= poll_timer_next;
      retries_left   <= retries_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
    if (step) begin
      out_phase        <= ring_phase_next;
      out_sms_due      <= sms_next;
      out_missed_call  <= miss_next;
      out_ring_enabled <= (pause_timer_next == 8'd0);
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'd0, out_ring_enabled, out_missed_call, out_sms_due, out_phase};

  `ASSERT_CLK_RST(a_step_gives_result, clk, rst, step |=> out_valid, "event processed but no result")
  `ASSERT_CLK_RST(a_miss_goes_idle, clk, rst, (out_valid && out_missed_call) |-> (out_phase == PH_IDLE), "missed call without return to idle")
  `ASSERT_CLK_RST(a_miss_not_sms, clk, rst, out_valid |-> !(out_missed_call && out_sms_due), "missed call and SMS due in one result")
  `ASSERT_CLK(a_stall_needs_item, clk, !s_tready |-> (in_valid && out_valid), "input stalled with a free stage")

endmodule
